@@ hdl/sha512_hash_engine_defines.svh @@
// ----------------------------------------------------------------------------
// SHA-512 hash engine: shared assertion macros
// Immediate-implication and next-cycle-implication checks on clk / rst_n.
// ----------------------------------------------------------------------------
`ifndef SHA512_HASH_ENGINE_DEFINES_SVH
`define SHA512_HASH_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define SHA_ASSERT_IMP(lbl, ante, cons) lbl: assert property (@(posedge clk) \
    disable iff (!rst_n) (ante) |-> (cons)) else $error("sha512 check failed");

// Next-cycle implication, disabled while reset is asserted
`define SHA_ASSERT_NXT(lbl, ante, cons) lbl: assert property (@(posedge clk) \
    disable iff (!rst_n) (ante) |=> (cons)) else $error("sha512 check failed");

`endif

@@ hdl/sha512_pkg.sv @@
// ----------------------------------------------------------------------------
// SHA-512 package
// Types, round constants, initial hash value and sigma functions.
// ----------------------------------------------------------------------------
package sha512_pkg;

    localparam int WordW       = 64;
    localparam int BlockWords  = 16;
    localparam int Rounds      = 80;
    localparam int DigestWords = 8;

    typedef logic [WordW-1:0] word_t;
    typedef logic [6:0]       round_idx_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_UPDATE
    } state_t;

    // Controls toward the schedule window
    typedef struct packed {
        logic push;
        logic step;
    } sched_ctrl_t;

    // Controls toward the round datapath
    typedef struct packed {
        logic load;
        logic step;
    } round_ctrl_t;

    localparam logic [7:0] PAD_MARKER     = 8'h80;
    localparam logic [3:0] FULL_BYTES     = 4'd8;
    localparam logic [3:0] LEN_HI_POS     = 4'd14;
    localparam logic [3:0] LEN_LO_POS     = 4'd15;
    localparam word_t      BYTES_PER_WORD = 64'd8;

    localparam word_t ROUND_K [Rounds] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    localparam word_t INIT_HASH [DigestWords] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    // Rotate right by a constant amount
    function automatic word_t rotr(input word_t x, input int unsigned n);
        return (x >> n) | (x << (WordW - n));
    endfunction

    function automatic word_t big_sigma0(input word_t x);
        return rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        return rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        return rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        return rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
    endfunction

endpackage

@@ hdl/sha512_sched.sv @@
// ----------------------------------------------------------------------------
// SHA-512 message schedule
// Sixteen-word sliding window: filled by pushed words, then extended by one
// schedule word per round. The oldest word is the round's W input.
// ----------------------------------------------------------------------------
module sha512_sched
    import sha512_pkg::*;
(
    input  logic        clk,
    input  sched_ctrl_t ctrl,
    input  word_t       push_word,
    output word_t       w_cur
);

    word_t win_reg [BlockWords];
    word_t new_word;
    word_t shift_in;

    // Next schedule word from the window taps
    always_comb
    begin
        new_word = small_sigma1(win_reg[14]) + win_reg[9]
                 + small_sigma0(win_reg[1]) + win_reg[0];
        shift_in = ctrl.push ? push_word : new_word;
    end

    // Window shifts toward index 0
    always_ff @(posedge clk)
    begin
        if (ctrl.push || ctrl.step)
        begin
            for (int i = 0; i < BlockWords - 1; i++)
            begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[BlockWords-1] <= shift_in;
        end
    end

    assign w_cur = win_reg[0];

endmodule

@@ hdl/sha512_round.sv @@
// ----------------------------------------------------------------------------
// SHA-512 round unit
// Holds the eight working variables and applies one compression round per
// cycle; loaded from the chaining value at the start of each block.
// ----------------------------------------------------------------------------
module sha512_round
    import sha512_pkg::*;
(
    input  logic        clk,
    input  round_ctrl_t ctrl,
    input  word_t       chain_in [DigestWords],
    input  word_t       k_in,
    input  word_t       w_in,
    output word_t       vars     [DigestWords]
);

    word_t v_reg [DigestWords];
    word_t ch;
    word_t maj;
    word_t t1;
    word_t t2;

    // Round function
    always_comb
    begin
        ch  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1  = v_reg[7] + big_sigma1(v_reg[4]) + ch + k_in + w_in;
        t2  = big_sigma0(v_reg[0]) + maj;
    end

    // Working variable registers
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            v_reg <= chain_in;
        end
        else if (ctrl.step)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    assign vars = v_reg;

endmodule

@@ hdl/sha512_out.sv @@
// ----------------------------------------------------------------------------
// SHA-512 digest output stage
// Captures the eight digest words and drains them one transaction per cycle
// while hash_stall is low, so the core can start on the next message meanwhile.
// ----------------------------------------------------------------------------
module sha512_out
    import sha512_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  word_t       digest_in [DigestWords],
    input  logic        hash_stall,
    output logic        hash_valid,
    output word_t       hash_word,
    output logic [2:0]  word_index,
    output logic        last_result,
    output logic        busy
);

    word_t      digest_reg [DigestWords];
    logic       valid_reg;
    logic [2:0] idx_reg;
    logic       out_accept;

    assign out_accept = valid_reg && !hash_stall;

    // Control: valid flag and word counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end
        else if (out_accept)
        begin
            idx_reg <= idx_reg + 3'd1;
            if (idx_reg == 3'(DigestWords - 1))
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Digest shift register, word 0 at the head
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            digest_reg <= digest_in;
        end
        else if (out_accept)
        begin
            for (int i = 0; i < DigestWords - 1; i++)
            begin
                digest_reg[i] <= digest_reg[i+1];
            end
        end
    end

    assign hash_valid  = valid_reg;
    assign hash_word   = digest_reg[0];
    assign word_index  = idx_reg;
    assign last_result = (idx_reg == 3'(DigestWords - 1));
    assign busy        = valid_reg;

endmodule

@@ hdl/sha512_hash_engine.sv @@
// Message words are taken while idle; the sixteenth word of a block starts the compression,
// the rounds in ST_ROUND, then a chaining update in ST_UPDATE; msg_stall is high meanwhile.
// After the last word, padding words go in one per cycle up to the block end, and each full
// block is compressed; digest words then follow one per cycle while hash_stall is low.
// Reset (async, active low) restores the initial hash value and clears all counters.
// ----------------------------------------------------------------------------
// SHA-512 hash engine top level
// Streams 64-bit message words, pads the final block, runs the 80-round
// compression on a shared round unit and emits the eight digest words.
// ----------------------------------------------------------------------------
`include "sha512_hash_engine_defines.svh"

module sha512_hash_engine
    import sha512_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        msg_valid,
    output logic        msg_stall,
    input  logic [63:0] message_word,
    input  logic [3:0]  valid_bytes,
    input  logic        last_word,
    output logic        hash_valid,
    input  logic        hash_stall,
    output logic [63:0] hash_word,
    output logic [2:0]  word_index,
    output logic        last_result
);

    state_t      state_reg, state_next;
    logic [3:0]  pos_reg, pos_next;
    word_t       count_reg, count_next;
    round_idx_t  round_reg, round_next;
    logic        padding_reg, padding_next;
    logic        marker_reg, marker_next;
    logic        len_hi_reg, len_hi_next;
    logic        final_reg, final_next;
    word_t       chain_reg [DigestWords];
    word_t       chain_next [DigestWords];

    logic        msg_accept;
    logic [3:0]  nb_sat;
    word_t       last_data;
    word_t       push_data;
    logic        push;
    sched_ctrl_t sched_ctrl;
    round_ctrl_t round_ctrl;
    word_t       w_cur;
    word_t       vars [DigestWords];
    word_t       sums [DigestWords];
    logic        out_load;
    logic        out_busy;

    assign msg_stall  = (state_reg != ST_IDLE);
    assign msg_accept = msg_valid && !msg_stall;

    // Final word: keep the valid bytes, place the 0x80 marker right after them when fewer than eight are valid
    always_comb
    begin
        nb_sat = (valid_bytes > FULL_BYTES) ? FULL_BYTES : valid_bytes;
        for (int b = 0; b < 8; b++)
        begin
            if (b < int'(nb_sat))
            begin
                last_data[63-8*b -: 8] = message_word[63-8*b -: 8];
            end
            else if (b == int'(nb_sat))
            begin
                last_data[63-8*b -: 8] = PAD_MARKER;
            end
            else
            begin
                last_data[63-8*b -: 8] = 8'h00;
            end
        end
    end

    // Chaining value plus working variables
    always_comb
    begin
        for (int i = 0; i < DigestWords; i++)
        begin
            sums[i] = chain_reg[i] + vars[i];
        end
    end

    // Sequencer: next state and controls
    always_comb
    begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        count_next    = count_reg;
        round_next    = round_reg;
        padding_next  = padding_reg;
        marker_next   = marker_reg;
        len_hi_next   = len_hi_reg;
        final_next    = final_reg;
        chain_next    = chain_reg;
        push          = 1'b0;
        push_data     = '0;
        round_ctrl    = '0;
        sched_ctrl    = '0;
        out_load      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (msg_accept)
                begin
                    push = 1'b1;
                    if (last_word)
                    begin
                        push_data    = last_data;
                        count_next   = count_reg + {60'd0, nb_sat};
                        padding_next = 1'b1;
                        marker_next  = (nb_sat == FULL_BYTES);
                        len_hi_next  = 1'b0;
                        final_next   = 1'b0;
                        state_next   = ST_PAD;
                    end
                    else
                    begin
                        push_data  = message_word;
                        count_next = count_reg + BYTES_PER_WORD;
                    end
                end
            end

            ST_PAD:
            begin
                push        = 1'b1;
                marker_next = 1'b0;
                if (marker_reg)
                begin
                    push_data = {PAD_MARKER, 56'd0};
                end
                else if (pos_reg == LEN_HI_POS)
                begin
                    push_data   = count_reg >> 61;
                    len_hi_next = 1'b1;
                end
                else if (pos_reg == LEN_LO_POS && len_hi_reg)
                begin
                    push_data  = count_reg << 3;
                    final_next = 1'b1;
                end
                else
                begin
                    push_data = '0;
                end
            end

            ST_ROUND:
            begin
                round_ctrl.step = 1'b1;
                sched_ctrl.step = 1'b1;
                round_next      = round_reg + 7'd1;
                if (round_reg == 7'(Rounds - 1))
                begin
                    state_next = ST_UPDATE;
                end
            end

            ST_UPDATE:
            begin
                if (final_reg)
                begin
                    // Hand the digest over once the output stage is free
                    if (!out_busy)
                    begin
                        out_load     = 1'b1;
                        chain_next   = INIT_HASH;
                        count_next   = '0;
                        padding_next = 1'b0;
                        final_next   = 1'b0;
                        state_next   = ST_IDLE;
                    end
                end
                else
                begin
                    chain_next = sums;
                    state_next = padding_reg ? ST_PAD : ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A push fills the window; the sixteenth word starts the rounds
        if (push)
        begin
            sched_ctrl.push = 1'b1;
            pos_next        = pos_reg + 4'd1;
            if (pos_reg == LEN_LO_POS)
            begin
                round_ctrl.load = 1'b1;
                round_next      = '0;
                state_next      = ST_ROUND;
            end
        end
    end

    // Sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            pos_reg     <= '0;
            count_reg   <= '0;
            round_reg   <= '0;
            padding_reg <= 1'b0;
            marker_reg  <= 1'b0;
            len_hi_reg  <= 1'b0;
            final_reg   <= 1'b0;
            chain_reg   <= INIT_HASH;
        end
        else
        begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            count_reg   <= count_next;
            round_reg   <= round_next;
            padding_reg <= padding_next;
            marker_reg  <= marker_next;
            len_hi_reg  <= len_hi_next;
            final_reg   <= final_next;
            chain_reg   <= chain_next;
        end
    end

    sha512_sched u_sched (
        .clk       (clk),
        .ctrl      (sched_ctrl),
        .push_word (push_data),
        .w_cur     (w_cur)
    );

    sha512_round u_round (
        .clk      (clk),
        .ctrl     (round_ctrl),
        .chain_in (chain_reg),
        .k_in     (ROUND_K[round_reg]),
        .w_in     (w_cur),
        .vars     (vars)
    );

    sha512_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (out_load),
        .digest_in   (sums),
        .hash_stall  (hash_stall),
        .hash_valid  (hash_valid),
        .hash_word   (hash_word),
        .word_index  (word_index),
        .last_result (last_result),
        .busy        (out_busy)
    );

    // Checks
    `SHA_ASSERT_IMP(a_load_when_free, out_load, !out_busy)
    `SHA_ASSERT_NXT(a_full_block_starts_rounds,
        msg_accept && !last_word && pos_reg == LEN_LO_POS,
        state_reg == ST_ROUND && round_reg == '0)
    `SHA_ASSERT_IMP(a_idle_no_padding, state_reg == ST_IDLE, !padding_reg && !final_reg)
    `SHA_ASSERT_IMP(a_final_at_block_start, final_reg, pos_reg == '0 && padding_reg)

endmodule
